/* rtl/vital_sign_alert_qualifier_top_macros.svh */
// ----------------------------------------------------------------------------
// Vital sign alert qualifier assertion macros
// Concurrent check macros shared by the RTL that asserts.
// ----------------------------------------------------------------------------
`ifndef VITAL_SIGN_ALERT_QUALIFIER_TOP_MACROS_SVH
`define VITAL_SIGN_ALERT_QUALIFIER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define VSAQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define VSAQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/vsaq_pkg.sv */
// ----------------------------------------------------------------------------
// Vital sign alert qualifier package
// Word types, limits, register indexes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vsaq_pkg;

	localparam int VSAQ_RING_DEPTH = 250;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_THR_ONE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THR_TWO   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THR_THREE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THR_FOUR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THR_FIVE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CONF_MIN  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STALE     = 3'd6;

	localparam logic [7:0] THR_ONE_RST   = 8'd10;
	localparam logic [7:0] THR_TWO_RST   = 8'd10;
	localparam logic [7:0] THR_THREE_RST = 8'd20;
	localparam logic [7:0] THR_FOUR_RST  = 8'd15;
	localparam logic [7:0] THR_FIVE_RST  = 8'd20;
	localparam logic [9:0] CONF_MIN_RST  = 10'd700;
	localparam logic [3:0] STALE_RST     = 4'd4;

	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	localparam logic [2:0] CLS_HEALTHY = 3'd0;
	localparam logic [2:0] CLS_ONE     = 3'd1;
	localparam logic [2:0] CLS_TWO     = 3'd2;
	localparam logic [2:0] CLS_THREE   = 3'd3;
	localparam logic [2:0] CLS_FOUR    = 3'd4;
	localparam logic [2:0] CLS_FIVE    = 3'd5;
	localparam logic [2:0] CLS_NONE    = 3'd7;

	localparam logic [7:0] IDLE_NEEDED = 8'd3;
	localparam logic [3:0] STALE_MAX   = 4'd15;
	localparam logic [7:0] PERSIST_MAX = 8'd255;
	localparam int         ECG_MIN_HELD = 10;

	localparam logic [11:0] BPM_LO  = 12'd200;
	localparam logic [11:0] BPM_HI  = 12'd2500;
	localparam logic [9:0]  SPO2_LO = 10'd500;
	localparam logic [9:0]  SPO2_HI = 10'd1000;
	localparam logic [12:0] TEMP_LO = 13'd2800;
	localparam logic [12:0] TEMP_HI = 13'd4500;

	typedef struct packed {
		logic        action;
		logic [11:0] ecg_sample;
		logic [11:0] bpm_x10;
		logic [9:0]  spo2_raw_x10;
		logic [12:0] temp_x100;
		logic [2:0]  nn_class;
		logic [9:0]  conf_permille;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  alert_class;
		logic        sensors_valid;
		logic        bpm_valid;
		logic        spo2_valid;
		logic        temp_valid;
		logic        ecg_valid;
		logic [11:0] bpm_shown_x10;
		logic [9:0]  spo2_shown_x10;
		logic [7:0]  persist_count;
		logic [7:0]  needed_secs;
	} out_word_t;

endpackage

`default_nettype wire

/* rtl/vsaq_chan_if.sv */
// ----------------------------------------------------------------------------
// Vital sign alert qualifier channel
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vsaq_chan_if #(
	parameter type word_t = logic
) ();
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/vital_sign_alert_qualifier_top.sv */
// ----------------------------------------------------------------------------
// Vital sign alert qualifier
// ECG lead-off tracking, stale-rate watchdog, range checks, alert persistence.
// ----------------------------------------------------------------------------
// Usage:
//   vitals (sink) takes one word per cycle when ready: action 0 is an ECG
//   sample that updates the lead-off ring, action 1 is a one-second tick.
//   alerts (source) gives one word per tick and none per ECG sample.
//   cfg_wr_en/cfg_idx/cfg_wdata write the thresholds, the confidence minimum
//   and the stale limit; write only while the block is idle.
// Path: a tick's word is registered in the input stage, then in the output
//   register, from which alerts.valid is driven.
// Throughput: one word per cycle while ready, samples and ticks mixed
//   freely; one flag memory, read at accept, written at input-stage exit.
// Reset: registers return to their defaults, ring empty, count zero, no
//   class held. The ring memory needs no clearing pass.
// Stall: while a tick word waits in the output register, a following tick
//   waits in the input stage and vitals.ready drops; samples still flow
//   through as long as the input stage is not blocked by a tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vital_sign_alert_qualifier_top
	import vsaq_pkg::*;
#(
	parameter int RING_DEPTH = VSAQ_RING_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	vsaq_chan_if.sink                  vitals,
	vsaq_chan_if.source                alerts
);

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int N_W   = $clog2(RING_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
	localparam logic [N_W-1:0]   N_DEPTH  = N_W'(RING_DEPTH);
	localparam logic [N_W-1:0]   N_MIN    = N_W'(ECG_MIN_HELD);

	// configuration
	logic [7:0] thr_one_q, thr_two_q, thr_three_q, thr_four_q, thr_five_q;
	logic [9:0] conf_min_q;
	logic [3:0] stale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_one_q   <= THR_ONE_RST;
			thr_two_q   <= THR_TWO_RST;
			thr_three_q <= THR_THREE_RST;
			thr_four_q  <= THR_FOUR_RST;
			thr_five_q  <= THR_FIVE_RST;
			conf_min_q  <= CONF_MIN_RST;
			stale_q     <= STALE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				REG_THR_ONE:   thr_one_q   <= cfg_wdata[7:0];
				REG_THR_TWO:   thr_two_q   <= cfg_wdata[7:0];
				REG_THR_THREE: thr_three_q <= cfg_wdata[7:0];
				REG_THR_FOUR:  thr_four_q  <= cfg_wdata[7:0];
				REG_THR_FIVE:  thr_five_q  <= cfg_wdata[7:0];
				REG_CONF_MIN:  conf_min_q  <= cfg_wdata;
				REG_STALE:     stale_q     <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// handshake
	logic s1_valid_q;
	logic out_valid_q;
	logic s1_tick;
	logic s1_adv;
	logic in_acc;

	assign s1_adv       = s1_valid_q && (!s1_tick || !out_valid_q || alerts.ready);
	assign vitals.ready = !s1_valid_q || s1_adv;
	assign in_acc       = vitals.valid && vitals.ready;

	// input stage
	in_word_t         word_s1;
	logic [PTR_W-1:0] pos_s1;
	logic [N_W-1:0]   n_s1;
	logic             full_s1;
	logic             rd_flag_q;

	logic [PTR_W-1:0] write_pos_q;
	logic             ring_full_q;
	logic [N_W-1:0]   nz_count_q;

	logic ring_mem [RING_DEPTH];
	logic ring_we;
	logic flag_s1;

	assign s1_tick = (word_s1.action == ACT_TICK);
	assign flag_s1 = (word_s1.ecg_sample != '0);
	assign ring_we = s1_adv && !s1_tick;

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[pos_s1] <= flag_s1;
		end
		if (in_acc) begin
			rd_flag_q <= ring_mem[write_pos_q];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			word_s1 <= vitals.data;
			pos_s1  <= write_pos_q;
			full_s1 <= ring_full_q;
			n_s1    <= ring_full_q ? N_DEPTH : N_W'(write_pos_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			write_pos_q <= '0;
			ring_full_q <= 1'b0;
		end else begin
			if (in_acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (in_acc && vitals.data.action == ACT_SAMPLE) begin
				if (write_pos_q == PTR_LAST) begin
					write_pos_q <= '0;
					ring_full_q <= 1'b1;
				end else begin
					write_pos_q <= write_pos_q + PTR_W'(1);
				end
			end
		end
	end

	// tick evaluation
	logic [11:0] last_rate_q;
	logic [3:0]  unch_q;
	logic [7:0]  persist_q;
	logic [2:0]  prev_cls_q;

	logic [2:0]  cls;
	logic [3:0]  unch_nxt;
	logic        stale;
	logic [11:0] bpm;
	logic [9:0]  spo2;
	logic        bpm_ok, spo2_ok, temp_ok, ecg_ok, all_ok;
	logic [7:0]  thr_sel;
	logic [7:0]  persist_base;
	logic [7:0]  persist_nxt;
	logic [2:0]  prev_cls_nxt;
	logic [7:0]  needed;
	logic [2:0]  alert;

	always_comb begin
		cls = (word_s1.nn_class > CLS_FIVE) ? CLS_HEALTHY : word_s1.nn_class;

		if (word_s1.bpm_x10 != last_rate_q) begin
			unch_nxt = '0;
		end else if (unch_q < STALE_MAX) begin
			unch_nxt = unch_q + 4'd1;
		end else begin
			unch_nxt = unch_q;
		end
		stale = (unch_nxt >= stale_q);
		bpm   = stale ? '0 : word_s1.bpm_x10;
		spo2  = stale ? '0 : word_s1.spo2_raw_x10;

		bpm_ok  = (bpm > BPM_LO) && (bpm < BPM_HI);
		spo2_ok = (spo2 > SPO2_LO) && (spo2 <= SPO2_HI);
		temp_ok = (word_s1.temp_x100 > TEMP_LO) && (word_s1.temp_x100 < TEMP_HI);
		ecg_ok  = (n_s1 > N_MIN) && (nz_count_q > (n_s1 >> 1));
		all_ok  = bpm_ok && spo2_ok && temp_ok && ecg_ok;

		case (cls)
			CLS_ONE:   thr_sel = thr_one_q;
			CLS_TWO:   thr_sel = thr_two_q;
			CLS_THREE: thr_sel = thr_three_q;
			CLS_FOUR:  thr_sel = thr_four_q;
			CLS_FIVE:  thr_sel = thr_five_q;
			default:   thr_sel = IDLE_NEEDED;
		endcase

		persist_base = (cls != prev_cls_q) ? '0 : persist_q;
		persist_nxt  = '0;
		prev_cls_nxt = CLS_NONE;
		needed       = IDLE_NEEDED;
		alert        = CLS_HEALTHY;
		if (all_ok) begin
			prev_cls_nxt = cls;
			if (cls != CLS_HEALTHY) begin
				persist_nxt = (persist_base < PERSIST_MAX) ?
					persist_base + 8'd1 : persist_base;
				needed = thr_sel;
				if (persist_nxt >= thr_sel && word_s1.conf_permille >= conf_min_q) begin
					alert = cls;
				end
			end
		end
	end

	// state commit as the word leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_count_q  <= '0;
			last_rate_q <= '0;
			unch_q      <= '0;
			persist_q   <= '0;
			prev_cls_q  <= CLS_NONE;
		end else if (s1_adv) begin
			if (s1_tick) begin
				last_rate_q <= word_s1.bpm_x10;
				unch_q      <= unch_nxt;
				persist_q   <= persist_nxt;
				prev_cls_q  <= prev_cls_nxt;
			end else begin
				nz_count_q <= nz_count_q - N_W'(full_s1 & rd_flag_q) + N_W'(flag_s1);
			end
		end
	end

	// output register
	out_word_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && s1_tick) begin
			out_valid_q <= 1'b1;
		end else if (alerts.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_tick) begin
			out_q.alert_class    <= alert;
			out_q.sensors_valid  <= all_ok;
			out_q.bpm_valid      <= bpm_ok;
			out_q.spo2_valid     <= spo2_ok;
			out_q.temp_valid     <= temp_ok;
			out_q.ecg_valid      <= ecg_ok;
			out_q.bpm_shown_x10  <= bpm;
			out_q.spo2_shown_x10 <= spo2;
			out_q.persist_count  <= persist_nxt;
			out_q.needed_secs    <= needed;
		end
	end

	assign alerts.valid = out_valid_q;
	assign alerts.data  = out_q;

	// checks
	`include "vital_sign_alert_qualifier_top_macros.svh"

	`VSAQ_ASSERT_NOW(a_alert_needs_valid,
		alerts.valid && alerts.data.alert_class != CLS_HEALTHY,
		alerts.data.sensors_valid && alerts.data.persist_count >= alerts.data.needed_secs,
		"alert raised without valid sensors or enough persistence")

	`VSAQ_ASSERT_NOW(a_count_bounded,
		1'b1,
		nz_count_q <= (ring_full_q ? N_DEPTH : N_W'(write_pos_q)),
		"nonzero count exceeds flags held")

	`VSAQ_ASSERT_NEXT(a_tick_held_on_stall,
		s1_valid_q && s1_tick && out_valid_q && !alerts.ready,
		s1_valid_q && s1_tick,
		"stalled tick left the input stage")

	`VSAQ_ASSERT_NOW(a_no_class_no_persist,
		prev_cls_q == CLS_NONE || prev_cls_q == CLS_HEALTHY,
		persist_q == '0,
		"persistence counted with no anomalous class held")

endmodule

`default_nettype wire
